// File: sv/p2g_pkg.sv
`default_nettype none
package p2g_pkg;

  localparam int NODES = 4096;
  localparam int AW = $clog2(NODES);
  localparam int STORE_W = 40;

  localparam logic [2:0] MODE_CLR_MASS = 3'd0;
  localparam logic [2:0] MODE_CLR_VEL  = 3'd1;
  localparam logic [2:0] MODE_ADD_MASS = 3'd2;
  localparam logic [2:0] MODE_ADD_VEL  = 3'd3;
  localparam logic [2:0] MODE_READ     = 3'd4;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [11:0] node_index;
    logic        [16:0] weight;
    logic        [31:0] particle_mass;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
  } p2g_in_t;

  typedef struct packed {
    logic        [39:0] node_mass;
    logic signed [39:0] node_velocity_x;
    logic signed [39:0] node_velocity_y;
    logic signed [39:0] node_velocity_z;
  } p2g_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MLO,
    ST_MHI,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } p2g_state_e;

endpackage
`default_nettype wire

// File: sv/particle_to_grid_scatter.sv
// Clear modes sweep the stores over all NODES (4096) addresses; add mass and a
// read step through READ and LOAD, and a read then waits for the output beat to
// be taken. Add velocity steps through READ and LOAD, then per selected
// component runs two multiply passes, a 65-step radix-2 divide by the node mass
// and one write-back. One item at a time. After reset the block sweeps all four
// stores to zero before the first item is taken; dimensions resets to 1.
`default_nettype none
module particle_to_grid_scatter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire p2g_pkg::p2g_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output p2g_pkg::p2g_out_t       out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_data_i
);
  import p2g_pkg::*;

  p2g_state_e state_q, state_d;
  p2g_in_t    in_q;
  logic [1:0] dims_q;
  logic [3:0] clr_mask_q, clr_mask_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [32:0] wm_q, wm_d;
  logic [39:0] mass_q, mass_d;
  logic [39:0] vel_q [3];
  logic [64:0] acc_q, acc_d;
  logic [39:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [1:0]  comp_q, comp_d;
  p2g_out_t    out_q;
  logic        load_in, load_rd, load_out;

  logic [AW-1:0]  addr;
  logic           node_ok;
  logic [3:0]     we;
  logic [AW-1:0]  waddr;
  logic [39:0]    wdata;
  logic [39:0]    rdata [4];

  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] mul_p;

  logic signed [31:0] v_sel;
  logic               v_neg;
  logic [31:0]        v_mag;
  logic [40:0]        div_r;
  logic               div_ge;
  logic [40:0]        mass_sum;
  logic signed [39:0] contrib;
  logic signed [40:0] vel_sum;
  logic [39:0]        vel_new;
  logic [1:0]         comp_nx;
  logic               comp_nx_en;

  assign addr    = AW'(in_q.node_index);
  assign node_ok = 32'(in_q.node_index) < NODES;
  assign mul_p   = 50'(mul_a) * 50'(mul_b);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign out_data_o  = out_q;

  for (genvar g = 0; g < 4; g++) begin : g_store
    p2g_ram #(.WIDTH(STORE_W), .DEPTH(NODES)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (addr),
      .rdata_o (rdata[g])
    );
  end

  always_comb begin
    case (comp_q)
      2'd1:    v_sel = in_q.velocity_y;
      2'd2:    v_sel = in_q.velocity_z;
      default: v_sel = in_q.velocity_x;
    endcase
    v_neg = v_sel[31];
    v_mag = v_neg ? 32'(-v_sel) : 32'(v_sel);

    div_r  = {rem_q, acc_q[64]};
    div_ge = div_r >= {1'b0, mass_q};

    mass_sum = {1'b0, rdata[0]} + 41'(wm_q);

    if (v_neg) begin
      if (acc_q[64:40] != '0 || (acc_q[39] && acc_q[38:0] != '0)) begin
        contrib = {1'b1, 39'd0};
      end else begin
        contrib = 40'(-acc_q[39:0]);
      end
    end else begin
      if (acc_q[64:39] != '0) begin
        contrib = {1'b0, {39{1'b1}}};
      end else begin
        contrib = 40'(acc_q[38:0]);
      end
    end
    vel_sum = 41'(signed'(vel_q[comp_q])) + 41'(contrib);
    if (vel_sum[40] != vel_sum[39]) begin
      vel_new = vel_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      vel_new = vel_sum[39:0];
    end

    comp_nx    = comp_q + 2'd1;
    comp_nx_en = (comp_nx == 2'd1 && dims_q >= 2'd2) || (comp_nx == 2'd2 && dims_q == 2'd3);
  end

  always_comb begin
    state_d    = state_q;
    clr_mask_d = clr_mask_q;
    clr_d      = clr_q;
    wm_d       = wm_q;
    mass_d     = mass_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    comp_d     = comp_q;
    load_in    = 1'b0;
    load_rd    = 1'b0;
    load_out   = 1'b0;
    we         = '0;
    waddr      = addr;
    wdata      = '0;
    mul_a      = 33'(in_q.particle_mass);
    mul_b      = in_q.weight;

    case (state_q)
      ST_CLEAR: begin
        we    = clr_mask_q;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(NODES - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          case (in_data_i.mode)
            MODE_CLR_MASS: begin
              clr_mask_d = 4'b0001;
              state_d    = ST_CLEAR;
            end
            MODE_CLR_VEL: begin
              clr_mask_d = {dims_q == 2'd3, dims_q >= 2'd2, 1'b1, 1'b0};
              state_d    = ST_CLEAR;
            end
            MODE_ADD_MASS, MODE_ADD_VEL, MODE_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        wm_d    = mul_p[48:16];
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        load_rd = 1'b1;
        mass_d  = rdata[0];
        comp_d  = 2'd0;
        state_d = ST_IDLE;
        case (in_q.mode)
          MODE_ADD_MASS: begin
            we[0] = node_ok;
            wdata = mass_sum[40] ? '1 : mass_sum[39:0];
          end
          MODE_ADD_VEL: begin
            if (node_ok && rdata[0] != '0) begin
              state_d = ST_MLO;
            end
          end
          default: begin
            load_out = 1'b1;
            state_d  = ST_OUT;
          end
        endcase
      end
      ST_MLO: begin
        mul_a   = wm_q;
        mul_b   = {1'b0, v_mag[15:0]};
        acc_d   = 65'(mul_p);
        state_d = ST_MHI;
      end
      ST_MHI: begin
        mul_a   = wm_q;
        mul_b   = {1'b0, v_mag[31:16]};
        acc_d   = acc_q + {mul_p[48:0], 16'd0};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = div_ge ? 40'(div_r - {1'b0, mass_q}) : div_r[39:0];
        acc_d = {acc_q[63:0], div_ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        we[comp_q + 2'd1] = 1'b1;
        wdata = vel_new;
        if (comp_nx_en) begin
          comp_d  = comp_nx;
          state_d = ST_MLO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_mask_q <= 4'b1111;
      clr_q      <= '0;
      dims_q     <= 2'd1;
      cnt_q      <= '0;
      comp_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_mask_q <= clr_mask_d;
      clr_q      <= clr_d;
      cnt_q      <= cnt_d;
      comp_q     <= comp_d;
      if (cfg_valid_i) begin
        dims_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wm_q   <= wm_d;
    mass_q <= mass_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    if (load_in) begin
      in_q <= in_data_i;
    end
    if (load_rd) begin
      vel_q[0] <= rdata[1];
      vel_q[1] <= rdata[2];
      vel_q[2] <= rdata[3];
    end
    if (load_out) begin
      out_q.node_mass       <= node_ok ? rdata[0] : '0;
      out_q.node_velocity_x <= node_ok ? rdata[1] : '0;
      out_q.node_velocity_y <= node_ok ? rdata[2] : '0;
      out_q.node_velocity_z <= node_ok ? rdata[3] : '0;
    end
  end

endmodule
`default_nettype wire

// File: sv/p2g_ram.sv
`default_nettype none
module p2g_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: test/testbench.sv
module testbench;
  import p2g_pkg::*;

  localparam logic [39:0] MASS_MAX = 40'hFF_FFFF_FFFF;
  localparam logic signed [39:0] VEL_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] VEL_MIN = -40'sh7F_FFFF_FFFF - 40'sd1;
  localparam int DRAIN_CYCLES = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  p2g_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  p2g_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd1;

  logic [39:0] mass_grid [NODES];
  logic signed [39:0] vel_grid [3][NODES];
  logic [1:0] dims;
  p2g_out_t node_reads_q [$];
  int errors = 0;
  bit stall_en = 1'b1;

  always #10 clk = ~clk;

  particle_to_grid_scatter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  function automatic logic signed [39:0] vel_share(logic signed [31:0] v,
                                                   logic [63:0] wm, logic [39:0] mn);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (v < 0) ? 128'(-64'(v)) : 128'(v);
    q = (mag * 128'(wm)) / 128'(mn);
    if (v < 0) return (q > 128'(VEL_MAX) + 1) ? VEL_MIN : -$signed(40'(q));
    return (q > 128'(VEL_MAX)) ? VEL_MAX : $signed(40'(q));
  endfunction

  task automatic grid_apply(input p2g_in_t it);
    logic [63:0] wm;
    logic [64:0] ms;
    logic signed [41:0] vs;
    logic signed [31:0] vc [3];
    p2g_out_t r;
    int nc;
    wm = (64'(it.weight) * 64'(it.particle_mass)) >> 16;
    nc = (dims == 3) ? 3 : (dims == 2) ? 2 : 1;
    vc[0] = it.velocity_x; vc[1] = it.velocity_y; vc[2] = it.velocity_z;
    case (it.mode)
      MODE_CLR_MASS: foreach (mass_grid[i]) mass_grid[i] = '0;
      MODE_CLR_VEL: for (int c = 0; c < nc; c++) foreach (mass_grid[i]) vel_grid[c][i] = '0;
      MODE_ADD_MASS: begin
        ms = 65'(mass_grid[it.node_index]) + 65'(wm);
        mass_grid[it.node_index] = (ms > 65'(MASS_MAX)) ? MASS_MAX : ms[39:0];
      end
      MODE_ADD_VEL: if (mass_grid[it.node_index] != 0) begin
        for (int c = 0; c < nc; c++) begin
          vs = 42'(vel_grid[c][it.node_index]) +
               42'(vel_share(vc[c], wm, mass_grid[it.node_index]));
          vel_grid[c][it.node_index] = (vs > 42'(VEL_MAX)) ? VEL_MAX :
                                       (vs < 42'(VEL_MIN)) ? VEL_MIN : vs[39:0];
        end
      end
      MODE_READ: begin
        r.node_mass = mass_grid[it.node_index];
        r.node_velocity_x = vel_grid[0][it.node_index];
        r.node_velocity_y = vel_grid[1][it.node_index];
        r.node_velocity_z = vel_grid[2][it.node_index];
        node_reads_q = {node_reads_q, r};
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    p2g_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (node_reads_q.size() == 0) begin
        report("unexpected beat", out_data.node_mass, '0);
      end else begin
        w = node_reads_q.pop_front();
        if (out_data.node_mass !== w.node_mass) report("mass", out_data.node_mass, w.node_mass);
        if (out_data.node_velocity_x !== w.node_velocity_x)
          report("vx", out_data.node_velocity_x, w.node_velocity_x);
        if (out_data.node_velocity_y !== w.node_velocity_y)
          report("vy", out_data.node_velocity_y, w.node_velocity_y);
        if (out_data.node_velocity_z !== w.node_velocity_z)
          report("vz", out_data.node_velocity_z, w.node_velocity_z);
      end
    end
  end

  always @(posedge clk) out_stall <= stall_en && ($urandom_range(0, 3) == 0);

  task automatic send(input p2g_in_t it);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    grid_apply(it);
  endtask

  task automatic write_dims(input logic [1:0] d);
    in_valid <= 1'b0;
    while (node_reads_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dims = d;
  endtask

  function automatic p2g_in_t mk(logic [2:0] m, logic [11:0] n, logic [16:0] w,
                                 logic [31:0] pm, logic [31:0] vx, logic [31:0] vy,
                                 logic [31:0] vz);
    p2g_in_t it;
    it.mode = m; it.node_index = n; it.weight = w; it.particle_mass = pm;
    it.velocity_x = vx; it.velocity_y = vy; it.velocity_z = vz;
    return it;
  endfunction

  function automatic p2g_in_t rand_item(logic [11:0] base);
    p2g_in_t it;
    int k;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom};
    k = $urandom_range(0, 99);
    it.mode = (k < 35) ? MODE_ADD_MASS : (k < 70) ? MODE_ADD_VEL : (k < 96) ? MODE_READ :
              (k < 97) ? MODE_CLR_MASS : (k < 98) ? MODE_CLR_VEL : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) != 0) it.node_index = base + 12'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) it.weight = 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 3) == 0) it.particle_mass = 32'($urandom_range(0, 1 << 20));
    return it;
  endfunction

  p2g_in_t directed [20] = '{
    mk(MODE_READ, 12'd0, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd4095, '0, '0, '0, '0, '0),
    mk(MODE_ADD_VEL, 12'd5, 17'd65536, 32'h10000, 32'h10000, '0, '0),
    mk(MODE_ADD_MASS, 12'd5, 17'd65536, 32'h10000, '0, '0, '0),
    mk(MODE_ADD_VEL, 12'd5, 17'd65536, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'h1),
    mk(MODE_ADD_MASS, 12'd4095, 17'h1FFFF, 32'hFFFFFFFF, '0, '0, '0),
    mk(MODE_ADD_VEL, 12'd4095, 17'h1FFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, '0),
    mk(MODE_ADD_MASS, 12'd7, 17'd1, 32'd1, '0, '0, '0),
    mk(MODE_ADD_MASS, 12'd7, 17'd1, 32'h10000, '0, '0, '0),
    mk(MODE_ADD_VEL, 12'd7, 17'h1FFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, '0, '0),
    mk(MODE_ADD_VEL, 12'd7, 17'h1FFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, '0, '0),
    mk(3'd5, 12'd7, 17'h1FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
    mk(3'd7, 12'd7, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd5, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd7, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd4095, '0, '0, '0, '0, '0),
    mk(MODE_CLR_VEL, 12'd0, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd5, '0, '0, '0, '0, '0),
    mk(MODE_CLR_MASS, 12'd0, '0, '0, '0, '0, '0),
    mk(MODE_READ, 12'd5, '0, '0, '0, '0, '0)
  };

  initial begin
    logic [11:0] base;
    foreach (mass_grid[i]) begin
      mass_grid[i] = '0;
      for (int c = 0; c < 3; c++) vel_grid[c][i] = '0;
    end
    dims = 2'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send(directed[i]);
    write_dims(2'd3);
    foreach (directed[i]) send(directed[i]);
    for (int p = 0; p < 5; p++) begin
      write_dims(2'(p % 4));
      stall_en = (p != 2);
      base = 12'($urandom_range(0, 511) * 8);
      for (int j = 0; j < 200; j++) send(rand_item(base));
    end
    in_valid <= 1'b0;
    while (node_reads_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS particle_to_grid_scatter");
    else $display("FAIL particle_to_grid_scatter");
    $finish;
  end

  initial begin
    #200000000;
    $display("FAIL particle_to_grid_scatter");
    $finish;
  end
endmodule
